// File: src/normal_equation_accumulator_macros.svh
// Assertion macros for the normal equation accumulator.
// Used by the top level only; needs nothing else.
`ifndef NORMAL_EQUATION_ACCUMULATOR_MACROS_SVH
`define NORMAL_EQUATION_ACCUMULATOR_MACROS_SVH
// implication checked every clock outside reset
`define NEA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define NEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: src/nea_pkg.sv
// Shared types and constants for the normal equation accumulator.
// No dependencies.
package nea_pkg;
   localparam int MAX_FIT_DEF = 8;
   localparam logic [1:0] KIND_CURV = 2'd0;
   localparam logic [1:0] KIND_GRAD = 2'd1;
   localparam logic [1:0] KIND_CHI  = 2'd2;

   typedef struct packed {
      logic signed [31:0] deriv;
      logic signed [31:0] y_obs;
      logic signed [31:0] y_model;
      logic [30:0]        sigma;
      logic               point_last;
      logic               set_last;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         row_index;
      logic [2:0]         col_index;
      logic signed [63:0] value;
      logic               last_result;
   } rsp_type;

   // saturating signed 64-bit add
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
   endfunction
endpackage

// File: src/normal_equation_accumulator.sv
// Normal equation accumulator top: sequencer, one term unit, curvature memory,
// register stores. Uses nea_pkg, nea_term, nea_divider.
// Per request: a point's first derivative first waits for the divider; each
// derivative j issues its terms one a cycle, then drains the term pipeline.
// set_last adds F*(F+1)/2+F+1 results (curvature reads memory per result, the rest
// one a cycle unless stalled), then a memory clear. Sync reset; clear runs first.
`include "normal_equation_accumulator_macros.svh"
module normal_equation_accumulator #(
   parameter int MAX_FIT = nea_pkg::MAX_FIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nea_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nea_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [3:0]       csr_data
);
   localparam int TRI   = MAX_FIT * (MAX_FIT + 1) / 2;
   localparam int TW    = (TRI > 1) ? $clog2(TRI) : 1;
   localparam int JW    = (MAX_FIT > 1) ? $clog2(MAX_FIT) : 1;
   localparam int LAT   = 4;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_ISSUE = 4'd3;
   localparam logic [3:0] S_DRAIN = 4'd4;
   localparam logic [3:0] S_ECURV = 4'd5;
   localparam logic [3:0] S_EGRAD = 4'd6;
   localparam logic [3:0] S_ECHI  = 4'd7;
   localparam logic [3:0] S_WAIT  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  fit_ff;
   logic [3:0]  eff;
   logic [3:0]  pc_ff, pc_in;
   logic [JW-1:0] j_ff;
   logic [3:0]  k_ff, k_in;
   logic [TW-1:0] base_ff;
   nea_pkg::req_type item_ff;
   logic signed [31:0] inv_ff;
   logic signed [31:0] res_ff;
   logic signed [31:0] derivs [MAX_FIT];
   logic signed [63:0] grad [MAX_FIT];
   logic signed [63:0] chi_ff;
   logic signed [63:0] curv_mem [TRI];
   logic signed [63:0] curv_rd_ff;

   // term operand issue and pipeline tags
   logic               iss_v;
   logic signed [31:0] iss_a, iss_b;
   logic [1:0]         iss_kind;
   logic [TW-1:0]      iss_idx;
   logic [LAT-1:0]     tv_ff;
   logic [1:0]         tk_ff [LAT];
   logic [TW-1:0]      ti_ff [LAT];
   logic signed [63:0] term_q;

   logic        div_start, div_done;
   logic [31:0] div_q;
   logic [61:0] sig_sq;
   logic signed [32:0] rdiff;
   logic signed [31:0] rsat;

   // emission
   logic [3:0]    er_ff, er_in;
   logic [3:0]    ec_ff, ec_in;
   logic [TW-1:0] ea_ff, ea_in;
   logic          out_v_ff;
   nea_pkg::rsp_type out_ff;
   logic          emit_go;
   logic [TW-1:0] clr_ff;
   logic          rd_pend_ff;

   assign eff = (fit_ff == 4'd0) ? 4'd1 :
                (fit_ff > 4'(MAX_FIT)) ? 4'(MAX_FIT) : fit_ff;

   assign rdiff = 33'(item_ff.y_obs) - 33'(item_ff.y_model);
   assign rsat  = (rdiff > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (rdiff < -33'sh0_8000_0000) ? 32'sh8000_0000 : rdiff[31:0];

   assign sig_sq = 62'(req_data.sigma * req_data.sigma);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign emit_go   = !out_v_ff || !rsp_stall;

   nea_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .divisor(sig_sq), .done(div_done), .quotient(div_q)
   );

   nea_term u_term (
      .clock(clock), .a(iss_a), .b(iss_b), .w(inv_ff), .result(term_q)
   );

   // issue of one term per cycle: d*d_k for k=0..j, then r*d, then residual^2 for a point's first item
   always_comb begin
      iss_v    = 1'b0;
      iss_a    = item_ff.deriv;
      iss_b    = item_ff.deriv;
      iss_kind = nea_pkg::KIND_CURV;
      iss_idx  = base_ff + TW'(k_ff);
      k_in     = k_ff;
      if (state_ff == S_ISSUE) begin
         iss_v = 1'b1;
         k_in  = k_ff + 4'd1;
         if (k_ff <= 4'(j_ff)) begin
            if (k_ff != 4'(j_ff)) iss_b = derivs[k_ff[JW-1:0]];
         end else if (k_ff == 4'(j_ff) + 4'd1) begin
            iss_a = res_ff;
            iss_kind = nea_pkg::KIND_GRAD;
         end else begin
            iss_a = res_ff;
            iss_b = res_ff;
            iss_kind = nea_pkg::KIND_CHI;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      div_start = 1'b0;
      er_in     = er_ff;
      ec_in     = ec_ff;
      ea_in     = ea_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == TW'(TRI - 1)) state_in = S_IDLE;
         S_IDLE: if (req_valid) begin
            if (pc_ff >= eff || pc_ff == 4'd0) begin
               state_in  = S_DIV;
               div_start = 1'b1;
            end else begin
               state_in = S_ISSUE;
            end
         end
         S_DIV: if (div_done) state_in = S_ISSUE;
         S_ISSUE: begin
            // last issue: gradient, or chi-square for a point's first item
            if ((k_ff == 4'(j_ff) + 4'd1 && j_ff != '0) || k_ff == 4'(j_ff) + 4'd2)
               state_in = S_DRAIN;
         end
         S_DRAIN: if (tv_ff == '0) begin
            pc_in = 4'(j_ff) + 4'd1;
            if (item_ff.point_last || pc_in >= eff) pc_in = 4'd0;
            if (item_ff.set_last) begin
               state_in = S_ECURV;
               er_in = '0; ec_in = '0; ea_in = '0;
               pc_in = 4'd0;
            end else state_in = S_IDLE;
         end
         S_ECURV: if (rd_pend_ff && emit_go) begin
            ea_in = ea_ff + TW'(1);
            if (ec_ff == er_ff) begin
               ec_in = '0;
               er_in = er_ff + 4'd1;
               if (er_ff + 4'd1 == eff) begin
                  er_in = '0;
                  state_in = S_EGRAD;
               end
            end else ec_in = ec_ff + 4'd1;
         end
         S_EGRAD: if (emit_go && !rd_pend_ff) begin
            er_in = er_ff + 4'd1;
            if (er_ff + 4'd1 == eff) state_in = S_ECHI;
         end
         S_ECHI: if (emit_go && !rd_pend_ff) state_in = S_WAIT;
         S_WAIT: if (emit_go) state_in = S_CLEAR;
         default: state_in = S_CLEAR;
      endcase
   end

   // curvature memory: read for emission/accumulate, written on term return and during clear
   logic          wr_en;
   logic [TW-1:0] wr_idx;
   logic signed [63:0] wr_dat;
   logic [TW-1:0] rd_idx;
   logic signed [63:0] acc_old;

   assign rd_idx = (state_ff == S_ECURV) ? ea_ff : ti_ff[LAT-2];
   // read issued in the cycle before its term arrives; entries differ within a
   // request and the pipe drains between requests
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = ti_ff[LAT-1];
      wr_dat = nea_pkg::sat_add(curv_rd_ff, term_q);
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1; wr_idx = clr_ff; wr_dat = '0;
      end else if (tv_ff[LAT-1] && tk_ff[LAT-1] == nea_pkg::KIND_CURV)
         wr_en = 1'b1;
   end
   assign acc_old = curv_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) curv_mem[wr_idx] <= wr_dat;
      curv_rd_ff <= curv_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         fit_ff   <= 4'd8;
         pc_ff    <= '0;
         tv_ff    <= '0;
         out_v_ff <= 1'b0;
         clr_ff   <= '0;
         rd_pend_ff <= 1'b0;
         chi_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (csr_write) fit_ff <= csr_data;
         tv_ff    <= {tv_ff[LAT-2:0], iss_v};
         clr_ff   <= (state_ff == S_CLEAR) ? clr_ff + TW'(1) : '0;
         // read data of entry ea_ff is valid once the registered read has seen its address
         rd_pend_ff <= (state_ff == S_ECURV) && !(rd_pend_ff && emit_go);
         if (tv_ff[LAT-1] && tk_ff[LAT-1] == nea_pkg::KIND_CHI)
            chi_ff <= nea_pkg::sat_add(chi_ff, term_q);
         else if (state_ff == S_WAIT && emit_go) chi_ff <= '0;
         if (state_ff == S_ECURV && rd_pend_ff && emit_go) begin
            out_v_ff <= 1'b1;
            out_ff <= '{nea_pkg::KIND_CURV, er_ff[2:0], ec_ff[2:0], acc_old, 1'b0};
         end else if (state_ff == S_EGRAD && emit_go) begin
            out_v_ff <= 1'b1;
            out_ff <= '{nea_pkg::KIND_GRAD, er_ff[2:0], 3'd0, grad[er_ff[JW-1:0]], 1'b0};
         end else if (state_ff == S_ECHI && emit_go && !rd_pend_ff) begin
            out_v_ff <= 1'b1;
            out_ff <= '{nea_pkg::KIND_CHI, 3'd0, 3'd0, chi_ff, 1'b1};
         end else if (emit_go) out_v_ff <= 1'b0;
      end
      er_ff   <= er_in;
      ec_ff   <= ec_in;
      ea_ff   <= ea_in;
      k_ff    <= (state_ff == S_ISSUE) ? k_in : '0;
      tk_ff[0] <= iss_kind;
      ti_ff[0] <= iss_idx;
      for (int i = 1; i < LAT; i++) begin
         tk_ff[i] <= tk_ff[i-1];
         ti_ff[i] <= ti_ff[i-1];
      end
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_data;
         if (pc_ff >= eff) begin
            j_ff <= '0; base_ff <= '0;
         end else begin
            j_ff <= pc_ff[JW-1:0];
            base_ff <= TW'((8'(pc_ff) * 8'(pc_ff + 4'd1)) >> 1);
         end
      end
      if (state_ff == S_DIV && div_done) begin
         inv_ff <= div_q;
         res_ff <= rsat;
      end
      if (state_ff == S_ISSUE && k_ff == '0) derivs[j_ff] <= item_ff.deriv;
      if (reset || (state_ff == S_WAIT && emit_go)) begin
         for (int i = 0; i < MAX_FIT; i++) grad[i] <= '0;
      end else if (tv_ff[LAT-1] && tk_ff[LAT-1] == nea_pkg::KIND_GRAD)
         grad[j_ff] <= nea_pkg::sat_add(grad[j_ff], term_q);
   end

   `NEA_ASSERT_IMP(a_no_req_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `NEA_ASSERT_IMP(a_one_term_write, clock, reset, wr_en && state_ff == S_CLEAR,
      !(tv_ff[LAT-1] && tk_ff[LAT-1] == nea_pkg::KIND_CURV))
   `NEA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

// File: src/nea_divider.sv
// Restoring divider: inv_var = floor(2^48 / s^2), saturated to 32 bits.
// Uses nea_pkg nothing; one quotient bit per cycle.
module nea_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [61:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [62:0] rem_ff, rem_in;
   logic [48:0] quo_ff, quo_in;
   logic [61:0] div_ff, div_in;
   logic [62:0] trial;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      trial    = {rem_ff[61:0], (count_ff == 6'd48)};
      done     = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 6'd48;
         rem_in   = '0;
         quo_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // dividend is 2^48: a single one at the top bit
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[47:0], 1'b0};
         end
         if (count_ff == 6'd0) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            count_in = count_ff - 6'd1;
         end
      end
      if (div_ff == '0)
         quotient = 32'hFFFF_FFFF;
      else if (quo_in[48:32] != '0)
         quotient = 32'hFFFF_FFFF;
      else
         quotient = quo_in[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end
endmodule

// File: src/nea_term.sv
// Term unit: |a*b| * w >> 16, signed, saturated; pipelined.
// Uses no package items; 33x33 and 32x32 multipliers with registers between.
module nea_term (
   input  logic               clock,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic [31:0]        w,
   output logic signed [63:0] result
);
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [31:0] w1_ff, w2_ff;
   logic [32:0] ma, mb;
   logic [32:0] ma_ff, mb_ff;
   logic [63:0] p_ff;
   logic [63:0] tlo_ff, thi_ff;
   logic [63:0] r;

   assign ma = a[31] ? 33'(-{a[31], a}) : 33'({1'b0, a});
   assign mb = b[31] ? 33'(-{b[31], b}) : 33'({1'b0, b});

   always_comb begin
      if (thi_ff >= 64'h0000_8000_0000_0000)
         r = 64'h7FFF_FFFF_FFFF_FFFF;
      else begin
         r = {thi_ff[47:0], 16'd0} + {16'd0, tlo_ff[63:16]};
         if (r[63]) r = 64'h7FFF_FFFF_FFFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma;
      mb_ff   <= mb;
      neg1_ff <= a[31] ^ b[31];
      w1_ff   <= w;
      // magnitudes reach at most 2^31, product fits 64 bits
      p_ff    <= 64'(ma_ff * mb_ff);
      neg2_ff <= neg1_ff;
      w2_ff   <= w1_ff;
      tlo_ff  <= 64'(p_ff[31:0] * w2_ff);
      thi_ff  <= 64'(p_ff[63:32] * w2_ff);
      neg3_ff <= neg2_ff;
      result  <= neg3_ff ? -$signed(r) : $signed(r);
   end
endmodule

// File: verif/nea_checker.sv
// Checker for the normal equation accumulator: watches both channels,
// predicts results from accepted requests and compares. Depends on nea_pkg.
module nea_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  nea_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  nea_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [3:0]       csr_data,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIT_MAX = nea_pkg::MAX_FIT_DEF;
   localparam int TRI = FIT_MAX * (FIT_MAX + 1) / 2;
   localparam logic signed [63:0] POS_MAX = {1'b0, {63{1'b1}}};

   logic [3:0]         fit_reg;
   logic signed [63:0] derivs [FIT_MAX];
   logic [31:0]        weight;
   logic signed [63:0] resid;
   int                 counter;
   logic signed [63:0] curv [TRI];
   logic signed [63:0] grad [FIT_MAX];
   logic signed [63:0] chi_sq;
   nea_pkg::rsp_type   expected_rsp [$];

   function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sd9223372036854775807) return POS_MAX;
      if (s < -65'sd9223372036854775808) return {1'b1, 63'd0};
      return s[63:0];
   endfunction

   // a*b*w >> 16, magnitude truncated and saturated
   function automatic logic signed [63:0] weighted_product(logic signed [63:0] a,
                                                           logic signed [63:0] b,
                                                           logic [31:0] w);
      logic         neg;
      logic [63:0]  ma, mb;
      logic [127:0] full;
      logic [63:0]  r;
      neg = a[63] != b[63];
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      full = ma * mb * w;
      full = full >> 16;
      r = (full > 128'(POS_MAX)) ? POS_MAX : full[63:0];
      return neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic int active_fit();
      if (fit_reg == 0) return 1;
      if (fit_reg > FIT_MAX) return FIT_MAX;
      return fit_reg;
   endfunction

   task automatic clear_sums();
      for (int i = 0; i < TRI; i++) curv[i] = 0;
      for (int i = 0; i < FIT_MAX; i++) begin
         grad[i] = 0;
         derivs[i] = 0;
      end
      weight = 0;
      resid = 0;
      counter = 0;
      chi_sq = 0;
   endtask

   task automatic push_rsp(logic [1:0] k, int r, int c, logic signed [63:0] v, bit l);
      nea_pkg::rsp_type e;
      e.kind = k;
      e.row_index = r[2:0];
      e.col_index = c[2:0];
      e.value = v;
      e.last_result = l;
      expected_rsp.push_back(e);
   endtask

   task automatic accumulate(nea_pkg::req_type q);
      int f, j;
      logic signed [63:0] d, diff;
      logic [63:0] s2;
      logic [63:0] quot;
      f = active_fit();
      d = 64'(q.deriv);
      if (counter >= f) counter = 0;
      j = counter;
      if (j == 0) begin
         if (q.sigma == 0) quot = 64'hFFFF_FFFF;
         else begin
            s2 = 64'(q.sigma) * 64'(q.sigma);
            quot = (64'd1 << 48) / s2;
            if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
         end
         weight = quot[31:0];
         diff = 64'(q.y_obs) - 64'(q.y_model);
         if (diff > 64'sd2147483647) diff = 64'sd2147483647;
         if (diff < -64'sd2147483648) diff = -64'sd2147483648;
         resid = diff;
         chi_sq = add_sat(chi_sq, weighted_product(resid, resid, weight));
      end
      derivs[j] = d;
      for (int k = 0; k <= j; k++)
         curv[j*(j+1)/2+k] = add_sat(curv[j*(j+1)/2+k],
                                     weighted_product(d, derivs[k], weight));
      grad[j] = add_sat(grad[j], weighted_product(resid, d, weight));
      counter = j + 1;
      if (q.point_last || counter >= f) counter = 0;
      if (q.set_last) begin
         for (int r = 0; r < f; r++)
            for (int c = 0; c <= r; c++)
               push_rsp(nea_pkg::KIND_CURV, r, c, curv[r*(r+1)/2+c], 0);
         for (int r = 0; r < f; r++) push_rsp(nea_pkg::KIND_GRAD, r, 0, grad[r], 0);
         push_rsp(nea_pkg::KIND_CHI, 0, 0, chi_sq, 1);
         clear_sums();
      end
   endtask

   always @(posedge clock) begin
      nea_pkg::rsp_type e;
      if (reset) begin
         fit_reg = 4'd8;
         clear_sums();
         expected_rsp.delete();
         fail_count = 0;
         rsp_seen = 0;
      end else begin
         if (csr_write) fit_reg = csr_data;
         if (req_valid && !req_stall) accumulate(req_data);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected response: kind %0d value %0d", rsp_data.kind,
                      rsp_data.value);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.kind !== e.kind) begin
                  $error("kind: expected %0d, got %0d", e.kind, rsp_data.kind);
                  fail_count++;
               end
               if (rsp_data.row_index !== e.row_index) begin
                  $error("row_index: expected %0d, got %0d", e.row_index,
                         rsp_data.row_index);
                  fail_count++;
               end
               if (rsp_data.col_index !== e.col_index) begin
                  $error("col_index: expected %0d, got %0d", e.col_index,
                         rsp_data.col_index);
                  fail_count++;
               end
               if (rsp_data.value !== e.value) begin
                  $error("value: expected %0d, got %0d", e.value, rsp_data.value);
                  fail_count++;
               end
               if (rsp_data.last_result !== e.last_result) begin
                  $error("last_result: expected %0d, got %0d", e.last_result,
                         rsp_data.last_result);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsp.size();
   end
endmodule

// File: verif/normal_equation_accumulator_tb.sv
// Testbench top for the normal equation accumulator: clock, reset, requests,
// configuration phases and verdict. Depends on nea_pkg and nea_checker.
module normal_equation_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   nea_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   nea_pkg::rsp_type rsp_data;
   logic    csr_write = 0;
   logic [3:0] csr_data = '0;
   int      fail_count, pending_count, rsp_seen;
   int      sent = 0;
   bit      calm = 0;
   logic [3:0] fit_now = 4'd8;

   normal_equation_accumulator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   nea_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_seen(rsp_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
   end

   function automatic logic [31:0] rand_q();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_sigma();
      case ($urandom_range(5))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(255, 1));
         3: return 31'($urandom_range(200000, 1));
         default: return 31'($urandom);
      endcase
   endfunction

   // one request, holding it until taken
   task automatic send(logic [31:0] d, logic [31:0] yo, logic [31:0] ym,
                       logic [30:0] s, bit pl, bit sl, bit gaps);
      while (gaps && !calm && $urandom_range(99) < 30) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{deriv: d, y_obs: yo, y_model: ym, sigma: s,
                    point_last: pl, set_last: sl};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain_and_set(logic [3:0] v);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_write <= 1;
      csr_data <= v;
      fit_now = v;
      @(posedge clock);
      csr_write <= 0;
   endtask

   // a data set of well-formed points with random content, some broken
   task automatic random_set(int points);
      int f;
      logic [31:0] yo, ym;
      logic [30:0] s;
      f = (fit_now == 0) ? 1 : (fit_now > 8 ? 8 : fit_now);
      for (int p = 0; p < points; p++) begin
         int n;
         yo = rand_q();
         ym = rand_q();
         s = rand_sigma();
         n = f;
         if ($urandom_range(9) == 0) n = $urandom_range(f + 2, 1);
         for (int i = 0; i < n; i++)
            send(rand_q(), yo, ym, s,
                 (i == n - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                 (p == points - 1) && (i == n - 1), 1);
      end
   endtask

   initial begin
      logic [3:0] fits [6];
      fits = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd8};
      repeat (2) @(posedge clock);
      reset <= 0;
      // directed: extremes at full fit count (reset value)
      calm = 1;
      send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 0, 0, 0);
      for (int i = 1; i < 8; i++)
         send(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 0, 0, 0, i == 7, 0, 0);
      send(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0);
      send(32'hFFFF_0000, 0, 0, 31'd1, 1, 0, 0);       // short point
      send(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 31'h0001_0000, 0, 1, 0);
      calm = 0;
      // each phase sets a fit count, then random data sets
      for (int ph = 0; ph < 6; ph++) begin
         drain_and_set(fits[ph]);
         calm = (ph == 4);
         for (int k = 0; k < 5; k++) random_set($urandom_range(3, 1));
      end
      // fit count lowered mid-point: counter past the new count restarts the point
      for (int i = 0; i < 5; i++) send(rand_q(), rand_q(), rand_q(), rand_sigma(), 0, 0, 1);
      req_valid <= 0;
      @(posedge clock);
      repeat (120) @(posedge clock);
      csr_write <= 1;
      csr_data <= 4'd2;
      fit_now = 4'd2;
      @(posedge clock);
      csr_write <= 0;
      calm = 0;
      while (sent < 470) random_set($urandom_range(4, 1));
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d requests and %0d results over fit counts 0..15 incl. extremes.",
               sent, rsp_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("normal_equation_accumulator: match");
      else $display("normal_equation_accumulator: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("normal_equation_accumulator: mismatch");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+src
src/nea_pkg.sv
src/nea_divider.sv
src/nea_term.sv
src/normal_equation_accumulator.sv
verif/nea_checker.sv
verif/normal_equation_accumulator_tb.sv
